FILE: design/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
// No dependencies; every other file imports this package.
package fbpa_pkg;

  localparam int NUM_BLOCKS = 32;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = 6;
  localparam int ADDR_W     = 32;
  localparam int BB_W       = 16;
  localparam int PROD_W     = BB_W + CNT_W;
  localparam int STEP_W     = $clog2(IDX_W + 1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_DOUBLE  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] REG_POOL_BASE     = 2'd0;
  localparam logic [1:0] REG_BLOCK_BYTES   = 2'd1;
  localparam logic [1:0] REG_BLOCKS_IN_USE = 2'd2;

  localparam logic [ADDR_W-1:0] RST_POOL_BASE     = '0;
  localparam logic [BB_W-1:0]   RST_BLOCK_BYTES   = BB_W'(32);
  localparam logic [CNT_W-1:0]  RST_BLOCKS_IN_USE = CNT_W'(32);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_MUL,
    S_FREE_CHK,
    S_FREE_DIV,
    S_FREE_APPLY,
    S_CLEAR,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic       load_req;
    logic       scan_inc;
    logic       alloc_hit;
    logic       mul_load;
    logic       chk_load;
    logic       div_step;
    logic       free_clear;
    logic       map_clear;
    logic       set_status;
    logic [1:0] status;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic       scan_end;
    logic       scan_free;
    logic       range_bad;
    logic       step_last;
    logic       rem_zero;
    logic       bit_used;
    logic       out_ready;
  } stat_t;

endpackage

FILE: design/fbpa_ctrl.sv
// Sequencer of the fixed block pool allocator: one request at a time.
// Depends on fbpa_pkg; drives the datapath through cmd_t and reads stat_t.
module fbpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     req_type_i,
  input  fbpa_pkg::stat_t stat_i,
  output fbpa_pkg::cmd_t  cmd_o
);
  import fbpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          case (req_type_i)
            REQ_ALLOC: state_d = S_SCAN;
            REQ_FREE:  state_d = S_FREE_MUL;
            REQ_CLEAR: state_d = S_CLEAR;
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.scan_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_FULL;
          state_d          = S_FINISH;
        end else if (stat_i.scan_free) begin
          cmd_o.alloc_hit = 1'b1;
          state_d         = S_FINISH;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_FREE_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (stat_i.range_bad) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_INVALID;
          state_d          = S_FINISH;
        end else begin
          cmd_o.chk_load = 1'b1;
          state_d        = S_FREE_DIV;
        end
      end
      S_FREE_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.step_last) begin
          state_d = S_FREE_APPLY;
        end
      end
      S_FREE_APPLY: begin
        if (!stat_i.rem_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_INVALID;
        end else if (!stat_i.bit_used) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DOUBLE;
        end else begin
          cmd_o.free_clear = 1'b1;
        end
        state_d = S_FINISH;
      end
      S_CLEAR: begin
        cmd_o.map_clear = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_ready) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/fbpa_dp.sv
// Datapath of the fixed block pool allocator: registers, used map, scan index,
// free range check, restoring divider and output register. Depends on fbpa_pkg.
module fbpa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   free_address_i,
  input  fbpa_pkg::cmd_t                cmd_i,
  output fbpa_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]   block_address_o,
  output logic [fbpa_pkg::CNT_W-1:0]    used_blocks_o,
  output logic [fbpa_pkg::CNT_W-1:0]    free_blocks_o
);
  import fbpa_pkg::*;

  logic [ADDR_W-1:0]     pool_base_q;
  logic [BB_W-1:0]       block_bytes_q;
  logic [CNT_W-1:0]      blocks_in_use_q;
  logic [NUM_BLOCKS-1:0] used_map_q;
  logic [CNT_W-1:0]      used_total_q;
  logic                  out_valid_q;

  logic [ADDR_W-1:0]     addr_q;
  logic [CNT_W-1:0]      scan_idx_q;
  logic [ADDR_W-1:0]     res_addr_q;
  logic [1:0]            status_q;
  logic [PROD_W-1:0]     prod_q;
  logic [PROD_W-1:0]     rem_q;
  logic [IDX_W-1:0]      quot_q;
  logic [STEP_W-1:0]     step_q;

  logic [1:0]            status_out_q;
  logic [ADDR_W-1:0]     addr_out_q;
  logic [CNT_W-1:0]      used_out_q;
  logic [CNT_W-1:0]      free_out_q;

  logic [CNT_W-1:0]      count_w;
  logic [CNT_W-1:0]      used_d;
  logic [ADDR_W:0]       pool_end_w;
  logic [PROD_W-1:0]     divisor_w;
  logic [PROD_W:0]       trial_w;
  logic [IDX_W+BB_W-1:0] scan_off_w;

  assign count_w    = (blocks_in_use_q > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                             : blocks_in_use_q;
  assign pool_end_w = {1'b0, pool_base_q} + (ADDR_W+1)'(prod_q);
  assign divisor_w  = PROD_W'(block_bytes_q) << step_q;
  assign trial_w    = {1'b0, rem_q} - {1'b0, divisor_w};
  assign scan_off_w = (IDX_W+BB_W)'(scan_idx_q[IDX_W-1:0]) * (IDX_W+BB_W)'(block_bytes_q);

  always_comb begin
    used_d = used_total_q;
    if (cmd_i.alloc_hit) begin
      used_d = used_total_q + CNT_W'(1);
    end else if (cmd_i.free_clear && used_total_q != '0) begin
      used_d = used_total_q - CNT_W'(1);
    end else if (cmd_i.map_clear) begin
      used_d = '0;
    end
  end

  assign stat_o.scan_end  = (scan_idx_q >= count_w);
  assign stat_o.scan_free = !used_map_q[scan_idx_q[IDX_W-1:0]];
  assign stat_o.range_bad = (addr_q == '0) || (addr_q < pool_base_q)
                         || ({1'b0, addr_q} >= pool_end_w) || (block_bytes_q == '0);
  assign stat_o.step_last = (step_q == '0);
  assign stat_o.rem_zero  = (rem_q == '0);
  assign stat_o.bit_used  = used_map_q[quot_q];
  assign stat_o.out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q     <= RST_POOL_BASE;
      block_bytes_q   <= RST_BLOCK_BYTES;
      blocks_in_use_q <= RST_BLOCKS_IN_USE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POOL_BASE:     pool_base_q     <= cfg_wdata_i;
        REG_BLOCK_BYTES:   block_bytes_q   <= cfg_wdata_i[BB_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_map_q   <= '0;
      used_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      used_total_q <= used_d;
      if (cmd_i.alloc_hit) begin
        used_map_q[scan_idx_q[IDX_W-1:0]] <= 1'b1;
      end else if (cmd_i.free_clear) begin
        used_map_q[quot_q] <= 1'b0;
      end else if (cmd_i.map_clear) begin
        used_map_q <= '0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      addr_q     <= free_address_i;
      scan_idx_q <= '0;
      res_addr_q <= '0;
      status_q   <= ST_OK;
    end
    if (cmd_i.scan_inc) begin
      scan_idx_q <= scan_idx_q + CNT_W'(1);
    end
    if (cmd_i.alloc_hit) begin
      res_addr_q <= pool_base_q + ADDR_W'(scan_off_w);
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.mul_load) begin
      prod_q <= PROD_W'(block_bytes_q) * PROD_W'(count_w);
    end
    if (cmd_i.chk_load) begin
      rem_q  <= PROD_W'(addr_q - pool_base_q);
      quot_q <= '0;
      step_q <= STEP_W'(IDX_W - 1);
    end
    if (cmd_i.div_step) begin
      if (!trial_w[PROD_W]) begin
        rem_q <= trial_w[PROD_W-1:0];
        quot_q[step_q[$clog2(IDX_W)-1:0]] <= 1'b1;
      end
      step_q <= step_q - STEP_W'(1);
    end
    if (cmd_i.load_out) begin
      status_out_q <= status_q;
      addr_out_q   <= res_addr_q;
      used_out_q   <= used_total_q;
      free_out_q   <= (count_w > used_total_q) ? (count_w - used_total_q) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_out_q;
  assign block_address_o = addr_out_q;
  assign used_blocks_o   = used_out_q;
  assign free_blocks_o   = free_out_q;

endmodule

FILE: design/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: sequencer plus datapath.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
//
// One request is worked at a time; in_stall_o is high from acceptance until its
// result enters the output register, which holds it while out_stall_i is high.
// An allocate scans the used map one block per cycle, from block 0 up to the
// lowest free block, or up to the block count when the pool is full. A free
// runs a block-size multiply for the pool end, the range check, one quotient
// bit per cycle of a restoring divider (5 steps), the map update and the result;
// a free that fails the range check, and an unused request type, go straight to
// the result. A clear empties the map first. The used map is cleared by reset
// directly, so the block is ready right after reset.
module fixed_block_pool_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] free_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [fbpa_pkg::ADDR_W-1:0] block_address_o,
  output logic [fbpa_pkg::CNT_W-1:0]  used_blocks_o,
  output logic [fbpa_pkg::CNT_W-1:0]  free_blocks_o
);
  import fbpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbpa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .free_address_i  (free_address_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .block_address_o (block_address_o),
    .used_blocks_o   (used_blocks_o),
    .free_blocks_o   (free_blocks_o)
  );

endmodule

FILE: design/fbpa_checker.sv
// Port-level assertions of the fixed block pool allocator and their bind.
// Depends on fbpa_pkg; attaches to fixed_block_pool_allocator.
module fbpa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [fbpa_pkg::ADDR_W-1:0] block_address_o,
  input logic [fbpa_pkg::CNT_W-1:0]  used_blocks_o,
  input logic [fbpa_pkg::CNT_W-1:0]  free_blocks_o
);
  import fbpa_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
                                      && $stable(block_address_o)))
    else $error("stalled result dropped or changed");

  a_addr_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (block_address_o == '0))
    else $error("nonzero address on a failed request");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((CNT_W+1)'(used_blocks_o) + (CNT_W+1)'(free_blocks_o)
                     <= (CNT_W+1)'(NUM_BLOCKS)))
    else $error("used plus free blocks exceed the pool");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

FILE: sim/tb_fixed_block_pool_allocator.sv
// Self-checking testbench for the fixed block pool allocator.
// Uses fbpa_pkg and the fixed_block_pool_allocator top level; an internal pool
// model predicts every result, with directed and random requests, some under back-pressure.
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  used_blocks;
    logic [CNT_W-1:0]  free_blocks;
  } pool_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_index_i;
  logic [ADDR_W-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          req_type_i;
  logic [ADDR_W-1:0]   free_address_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          status_o;
  logic [ADDR_W-1:0]   block_address_o;
  logic [CNT_W-1:0]    used_blocks_o;
  logic [CNT_W-1:0]    free_blocks_o;

  fixed_block_pool_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .free_address_i  (free_address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .block_address_o (block_address_o),
    .used_blocks_o   (used_blocks_o),
    .free_blocks_o   (free_blocks_o)
  );

  always #6 clk_i = ~clk_i;

  // pool model state
  logic [NUM_BLOCKS-1:0] pool_used;
  logic [CNT_W-1:0]      pool_total;
  logic [ADDR_W-1:0]     pool_base_q;
  logic [BB_W-1:0]       block_bytes_q;
  logic [CNT_W-1:0]      block_limit_q;

  pool_result_t pending_results[$];
  pool_result_t head_result;
  int unsigned  err_cnt;
  int unsigned  cyc_cnt;
  int unsigned  burst_left;
  int unsigned  stall_mode;
  int unsigned  stall_run;
  int unsigned  hold_left;
  bit           stall_state;
  bit           hold_req;
  bit           pace_on;

  function automatic int unsigned active_blocks();
    return (block_limit_q > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_limit_q);
  endfunction

  function automatic pool_result_t pool_model_step(input logic [1:0] req,
                                                   input logic [ADDR_W-1:0] addr);
    pool_result_t r;
    int unsigned  n_blk;
    bit           found;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  off;
    logic [63:0]  idx;
    n_blk = active_blocks();
    r.status = ST_OK;
    r.block_address = '0;
    case (req)
      REQ_ALLOC: begin
        r.status = ST_FULL;
        found = 1'b0;
        for (int i = 0; i < n_blk; i++) begin
          if (!found && !pool_used[i]) begin
            found = 1'b1;
            pool_used[i] = 1'b1;
            pool_total = pool_total + 1'b1;
            r.block_address = pool_base_q + 32'(i) * {16'h0, block_bytes_q};
            r.status = ST_OK;
          end
        end
      end
      REQ_FREE: begin
        lo = {32'h0, pool_base_q};
        hi = lo + {48'h0, block_bytes_q} * 64'(n_blk);
        if (addr == '0 || {32'h0, addr} < lo || {32'h0, addr} >= hi || block_bytes_q == '0) begin
          r.status = ST_INVALID;
        end else begin
          off = {32'h0, addr} - lo;
          idx = off / {48'h0, block_bytes_q};
          if ((off % {48'h0, block_bytes_q}) != 0 || idx >= NUM_BLOCKS) begin
            r.status = ST_INVALID;
          end else if (!pool_used[idx[IDX_W-1:0]]) begin
            r.status = ST_DOUBLE;
          end else begin
            pool_used[idx[IDX_W-1:0]] = 1'b0;
            if (pool_total != '0) pool_total = pool_total - 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        pool_used = '0;
        pool_total = '0;
      end
      default: ;
    endcase
    r.used_blocks = pool_total;
    r.free_blocks = (n_blk > pool_total) ? CNT_W'(n_blk - pool_total) : '0;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_release_addr();
    int          used_idx[$];
    int unsigned n_blk;
    int unsigned sel;
    int unsigned k;
    logic [ADDR_W-1:0] a;
    n_blk = active_blocks();
    sel = $urandom_range(0, 99);
    for (int i = 0; i < NUM_BLOCKS; i++) if (pool_used[i]) used_idx.push_back(i);
    k = $urandom_range(0, (n_blk > 0) ? n_blk - 1 : 0);
    if (sel < 65 && used_idx.size() > 0) k = used_idx[$urandom_range(0, used_idx.size() - 1)];
    a = pool_base_q + 32'(k) * {16'h0, block_bytes_q};
    if (sel >= 80 && sel < 88)
      a = a + $urandom_range(1, (block_bytes_q > 1) ? block_bytes_q - 1 : 1);
    else if (sel >= 88 && sel < 91)
      a = pool_base_q + 32'(n_blk) * {16'h0, block_bytes_q};
    else if (sel >= 91 && sel < 93)
      a = pool_base_q - 1;
    else if (sel >= 93 && sel < 96)
      a = '0;
    else if (sel >= 96)
      a = $urandom;
    return a;
  endfunction

  task automatic send_req(input logic [1:0] req, input logic [ADDR_W-1:0] addr);
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    free_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(pool_model_step(req, addr));
    if (pace_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 6)) @(posedge clk_i);
        burst_left = $urandom_range(0, 20);
      end
    end
  endtask

  task automatic send_random_req();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 48)      send_req(REQ_ALLOC, $urandom);
    else if (sel < 94) send_req(REQ_FREE, pick_release_addr());
    else if (sel < 97) send_req(REQ_CLEAR, $urandom);
    else               send_req(REQ_UNUSED, $urandom);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic [ADDR_W-1:0] base, input logic [BB_W-1:0] bytes,
                           input logic [CNT_W-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_POOL_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    pool_base_q = base;
    cfg_index_i <= REG_BLOCK_BYTES;
    cfg_wdata_i <= {16'h0, bytes};
    @(posedge clk_i);
    block_bytes_q = bytes;
    cfg_index_i <= REG_BLOCKS_IN_USE;
    cfg_wdata_i <= {26'h0, count};
    @(posedge clk_i);
    block_limit_q = count;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_default_pool();
    pace_on = 1'b0;
    stall_mode = 0;
    send_req(REQ_ALLOC, 32'hFFFF_FFFF);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, $urandom);
    send_req(REQ_FREE, 32'h20);
    send_req(REQ_FREE, 32'h20);
    send_req(REQ_FREE, 32'h21);
    send_req(REQ_FREE, '0);
    send_req(REQ_FREE, 32'h400);
    send_req(REQ_UNUSED, 32'h5A5A_A5A5);
    send_req(REQ_CLEAR, '0);
  endtask

  task automatic test_address_wrap();
    drain_results();
    configure(32'hFFFF_FF00, 16'hFFFF, 6'd32);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, 32'h0000_FEFF);
    send_req(REQ_FREE, 32'hFFFF_FF00);
    send_req(REQ_FREE, 32'hFFFF_FFFF);
  endtask

  task automatic test_degenerate_sizes();
    drain_results();
    configure(32'h1234_5678, 16'h0, 6'd4);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, 32'h1234_5678);
    drain_results();
    configure(32'h100, 16'd32, 6'd0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, 32'h100);
    send_req(REQ_CLEAR, '0);
    drain_results();
    configure('0, 16'd1, 6'd1);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, '0);
  endtask

  task automatic test_shrunk_count();
    drain_results();
    configure(32'h8000, 16'd16, 6'd32);
    send_req(REQ_CLEAR, '0);
    repeat (4) send_req(REQ_ALLOC, '0);
    drain_results();
    configure(32'h8000, 16'd16, 6'd2);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, 32'h8030);
    send_req(REQ_FREE, 32'h8010);
    drain_results();
    configure(32'h8000, 16'd16, 6'd63);
    send_req(REQ_ALLOC, '0);
  endtask

  task automatic test_backpressure();
    drain_results();
    configure(32'h2000_0000, 16'd64, 6'd32);
    send_req(REQ_CLEAR, '0);
    stall_mode = 1;
    hold_req = 1'b1;
    repeat (33) send_req(REQ_ALLOC, $urandom);
    repeat (8) send_random_req();
  endtask

  task automatic test_random_pools();
    logic [ADDR_W-1:0] base;
    logic [BB_W-1:0]   bytes;
    logic [CNT_W-1:0]  count;
    int unsigned       n_items;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      base    = $urandom;
      bytes   = $urandom_range(1, 65535);
      count   = $urandom_range(1, 32);
      n_items = 210;
      case (ph)
        0: begin
          base  = '0;
          bytes = 16'd32;
          count = 6'd32;
        end
        1: count = 6'd32;
        2: begin
          base  = 32'hFFFF_0000;
          bytes = 16'hFFFF;
          count = 6'd32;
        end
        3: bytes = 16'd1;
        4: begin
          bytes = 16'd3;
          count = 6'd5;
        end
        5: begin
          base  = 32'hFFFF_FFFF;
          count = 6'd63;
        end
        6: count = $urandom_range(0, 63);
        default: begin
          base    = 32'h1000;
          bytes   = '0;
          count   = 6'd8;
          n_items = 60;
        end
      endcase
      configure(base, bytes, count);
      pace_on    = (ph != 0);
      stall_mode = (ph == 0) ? 0 : $urandom_range(1, 4);
      repeat (n_items) send_random_req();
    end
  endtask

  // receiver stall pattern and long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ((cyc_cnt % 11) < 4);
        3: out_stall_i <= ($urandom_range(0, 3) != 0);
        4: begin
          if (stall_run == 0) begin
            stall_state = ~stall_state;
            stall_run   = $urandom_range(1, 15);
          end
          stall_run--;
          out_stall_i <= stall_state;
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: status %0d address %h used %0d free %0d",
                   status_o, block_address_o, used_blocks_o, free_blocks_o);
      end else begin
        head_result = pending_results.pop_front();
        if (status_o !== head_result.status || block_address_o !== head_result.block_address ||
            used_blocks_o !== head_result.used_blocks ||
            free_blocks_o !== head_result.free_blocks) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch: expected status %0d address %h used %0d free %0d, ",
                      "got status %0d address %h used %0d free %0d"},
                     head_result.status, head_result.block_address, head_result.used_blocks,
                     head_result.free_blocks, status_o, block_address_o, used_blocks_o,
                     free_blocks_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("[fixed_block_pool_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= REG_POOL_BASE;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    req_type_i     <= REQ_ALLOC;
    free_address_i <= '0;
    out_stall_i    <= 1'b0;
    pool_used      = '0;
    pool_total     = '0;
    pool_base_q    = RST_POOL_BASE;
    block_bytes_q  = RST_BLOCK_BYTES;
    block_limit_q  = RST_BLOCKS_IN_USE;
    err_cnt        = 0;
    cyc_cnt        = 0;
    burst_left     = 0;
    stall_mode     = 0;
    stall_run      = 0;
    stall_state    = 1'b0;
    hold_left      = 0;
    hold_req       = 1'b0;
    pace_on        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_pool();
    test_address_wrap();
    test_degenerate_sizes();
    test_shrunk_count();
    test_backpressure();
    test_random_pools();

    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("[fixed_block_pool_allocator] OK");
    end else begin
      $display("[fixed_block_pool_allocator] ERROR");
    end
    $finish;
  end

endmodule
